FILE: hw/rtl/sm3_pkg.sv
// Package: SM3 constants, types and round helper functions.
`timescale 1ns / 1ps
package sm3_pkg;

	localparam int unsigned CntW = 61;
	localparam int unsigned QDepth = 4;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

	// One queued command for the back end
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

FILE: hw/rtl/sm3_stream_if.sv
// Interface: valid/ready stream channel with generic payload.
`timescale 1ns / 1ps
interface sm3_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sm3_front.sv
// Front end: accepts words, drops idle ones, queues commands.
`timescale 1ns / 1ps
module sm3_front #(
	parameter int unsigned Depth = sm3_pkg::QDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sm3_pkg::cmd_t     in_cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output sm3_pkg::cmd_t     q_cmd
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	sm3_pkg::cmd_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push;

	assign in_ready = (cnt_q != Depth[AW:0]);
	// idle words carry nothing and are dropped
	assign push = in_valid && in_ready && (in_cmd.has_byte || in_cmd.eom);
	assign q_valid = (cnt_q != '0);
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop};
		end
	end
endmodule

FILE: hw/rtl/sm3_core.sv
// Back end: block packing, padding, 64-round compression, digest output.
`timescale 1ns / 1ps
module sm3_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  sm3_pkg::cmd_t q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_word,
	output logic [2:0]    out_index,
	output logic          out_last
);
	sm3_pkg::state_t state_q, state_d;

	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [31:0] r_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic [sm3_pkg::CntW-1:0] cnt_q;
	logic        eom_q;     // end of message still to pad
	logic        len_q;     // length block still needed
	logic [1:0]  pad_q;     // 0 none, 1 pad block, 2 length block
	logic [2:0]  oidx_q;

	logic [5:0]  pos;
	logic        take, blk_full, start_blk;
	logic [31:0] wj, wj4, tj, ss1, ss2, tt1, tt2, ff, gg, a12, wnew, t;
	logic [3:0]  nidx;
	logic [63:0] bits;
	logic [31:0] w15;
	logic [31:0] fblk [16];

	assign pos = cnt_q[5:0];
	assign bits = {cnt_q, 3'b000};
	assign take = (state_q == sm3_pkg::ST_IDLE) && q_valid;
	assign blk_full = q_cmd.has_byte && (pos == 6'd63);

	// Expansion for word j+4 and round datapath
	always_comb begin
		nidx = rnd_q[3:0] + 4'd4;
		t = w_q[nidx] ^ w_q[4'(nidx - 4'd9)] ^ sm3_pkg::rotl(w_q[4'(nidx - 4'd3)], 5'd15);
		wnew = sm3_pkg::p1(t) ^ sm3_pkg::rotl(w_q[4'(nidx - 4'd13)], 5'd7)
			^ w_q[4'(nidx - 4'd6)];
		wj = w_q[rnd_q[3:0]];
		wj4 = (rnd_q >= 6'd12) ? wnew : w_q[nidx];
		tj = (rnd_q < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
		tt2 = gg + r_q[7] + ss1 + wj;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sm3_pkg::ST_IDLE:
				if (take && (blk_full || q_cmd.eom)) state_d = blk_full ?
					sm3_pkg::ST_ROUND : sm3_pkg::ST_PAD;
			sm3_pkg::ST_PAD: state_d = sm3_pkg::ST_ROUND;
			sm3_pkg::ST_LEN: state_d = sm3_pkg::ST_ROUND;
			sm3_pkg::ST_ROUND:
				if (rnd_q == 6'd63) begin
					if (eom_q) state_d = sm3_pkg::ST_PAD;
					else if (len_q) state_d = sm3_pkg::ST_LEN;
					else if (pad_q != 2'd0) state_d = sm3_pkg::ST_EMIT;
					else state_d = sm3_pkg::ST_IDLE;
				end
			sm3_pkg::ST_EMIT:
				if (out_ready && oidx_q == 3'd7) state_d = sm3_pkg::ST_IDLE;
			default: state_d = sm3_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop = take;
		out_valid = (state_q == sm3_pkg::ST_EMIT);
		out_word = v_q[oidx_q];
		out_index = oidx_q;
		out_last = (oidx_q == 3'd7);
		start_blk = (state_q == sm3_pkg::ST_PAD) || (state_q == sm3_pkg::ST_LEN)
			|| (take && blk_full);
	end

	// block load for a full data block: byte lands in word 15 this cycle
	always_comb begin
		w15 = buf_q[15];
		w15[7:0] = q_cmd.data;
	end

	// Final block contents: 0x80 then zero fill and length if it fits, or length only
	always_comb begin
		for (int k = 0; k < 16; k++) fblk[k] = buf_q[k];
		if (state_q == sm3_pkg::ST_LEN) begin
			for (int k = 0; k < 14; k++) fblk[k] = '0;
			fblk[14] = bits[63:32];
			fblk[15] = bits[31:0];
		end else begin
			for (int k = 0; k < 64; k++) begin
				if (k == int'(pos)) fblk[k/4][(3 - k%4) * 8 +: 8] = sm3_pkg::PAD_BYTE;
				else if (k > int'(pos)) fblk[k/4][(3 - k%4) * 8 +: 8] = 8'h00;
			end
			if (pos < 6'd56) begin
				fblk[14] = bits[63:32];
				fblk[15] = bits[31:0];
			end
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (take && q_cmd.has_byte) buf_q[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= q_cmd.data;
		if (state_q == sm3_pkg::ST_PAD || state_q == sm3_pkg::ST_LEN) begin
			for (int k = 0; k < 16; k++) begin
				buf_q[k] <= fblk[k];
				w_q[k] <= fblk[k];
			end
		end
		if (state_q == sm3_pkg::ST_ROUND && rnd_q >= 6'd12) w_q[nidx] <= wnew;
		if (take && blk_full) begin
			for (int k = 0; k < 15; k++) w_q[k] <= buf_q[k];
			w_q[15] <= w15;
		end
	end

	// Control and chaining registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::ST_IDLE;
			rnd_q <= '0;
			cnt_q <= '0;
			eom_q <= 1'b0;
			len_q <= 1'b0;
			pad_q <= '0;
			oidx_q <= '0;
			for (int k = 0; k < 8; k++) begin
				v_q[k] <= sm3_pkg::IV[255 - 32*k -: 32];
				r_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (take) begin
				if (q_cmd.has_byte) cnt_q <= cnt_q + 1'b1;
				// byte with end flag on a full block: compress, then pad
				eom_q <= q_cmd.eom && blk_full;
			end
			if (start_blk) begin
				for (int k = 0; k < 8; k++) r_q[k] <= v_q[k];
				rnd_q <= '0;
			end
			if (state_q == sm3_pkg::ST_PAD) begin
				eom_q <= 1'b0;
				pad_q <= 2'd1;
				len_q <= (pos >= 6'd56);
			end
			if (state_q == sm3_pkg::ST_LEN) begin
				len_q <= 1'b0;
				pad_q <= 2'd2;
			end
			if (state_q == sm3_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
				r_q[3] <= r_q[2];
				r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
				r_q[1] <= r_q[0];
				r_q[0] <= tt1;
				r_q[7] <= r_q[6];
				r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
				r_q[5] <= r_q[4];
				r_q[4] <= sm3_pkg::p0(tt2);
				if (rnd_q == 6'd63) begin
					v_q[0] <= v_q[0] ^ tt1;
					v_q[1] <= v_q[1] ^ r_q[0];
					v_q[2] <= v_q[2] ^ sm3_pkg::rotl(r_q[1], 5'd9);
					v_q[3] <= v_q[3] ^ r_q[2];
					v_q[4] <= v_q[4] ^ sm3_pkg::p0(tt2);
					v_q[5] <= v_q[5] ^ r_q[4];
					v_q[6] <= v_q[6] ^ sm3_pkg::rotl(r_q[5], 5'd19);
					v_q[7] <= v_q[7] ^ r_q[6];
				end
			end
			if (state_q == sm3_pkg::ST_EMIT && out_ready) begin
				oidx_q <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					for (int k = 0; k < 8; k++) v_q[k] <= sm3_pkg::IV[255 - 32*k -: 32];
					cnt_q <= '0;
					pad_q <= '0;
				end
			end
		end
	end
endmodule

FILE: hw/rtl/sm3_hash_engine.sv
// Top level: SM3 hash engine, byte input stream, digest word output stream.
//
//  channel | dir | payload
//  in_ch   | in  | data_byte[8], byte_valid, end_of_message
//  out_ch  | out | digest_word[32], word_index[3], last_word
//
// A byte is stored while the core is idle; the 64th byte of a block starts
// compression, one round per cycle in the shared round unit. End of
// message adds a load step plus 64 rounds per final block, then 8 words.
// Idle words are dropped in the front queue; a full queue drops in_ch.ready.
// Reset loads the IV and clears all control state.
`timescale 1ns / 1ps
module sm3_hash_engine #(
	parameter int unsigned QueueDepth = sm3_pkg::QDepth
) (
	input logic clk,
	input logic arst_n,
	sm3_stream_if.sink   in_ch,
	sm3_stream_if.source out_ch
);
	sm3_pkg::cmd_t cmd_in, q_cmd;
	logic q_valid, q_pop;

	assign cmd_in.data = in_ch.data.data_byte;
	assign cmd_in.has_byte = in_ch.data.byte_valid;
	assign cmd_in.eom = in_ch.data.end_of_message;

	sm3_front #(.Depth(QueueDepth)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(cmd_in),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	sm3_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_word(out_ch.data.digest_word), .out_index(out_ch.data.word_index),
		.out_last(out_ch.data.last_word)
	);

	// The core never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	// Last flag only on word seven
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.data.last_word == (out_ch.data.word_index == 3'd7)))
		else $error("last flag mismatch");
	// Core takes no command while emitting
	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> !q_pop)
		else $error("pop during digest output");
endmodule

FILE: dv/tb_top.sv
// Testbench: SM3 hash engine checked against a behavioral SM3 digest predictor.
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned DrainCycles = 300;

	logic clk;
	logic arst_n;

	sm3_stream_if #(.payload_t(in_word_t))  in_ch (clk);
	sm3_stream_if #(.payload_t(out_word_t)) out_ch (clk);

	sm3_hash_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Predictor state: chaining value, partial block, message byte count
	logic [31:0] chain[8];
	logic [31:0] blk[16];
	logic [60:0] msg_bytes;

	in_word_t  pending_words[$];
	out_word_t digest_expected[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned digests_queued;
	bit quiet;

	function automatic logic [31:0] rot(input logic [31:0] x, input int unsigned n);
		int unsigned k;
		k = n % 32;
		if (k == 0)
			return x;
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rot(x, 9) ^ rot(x, 17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rot(x, 15) ^ rot(x, 23);
	endfunction

	function automatic void chain_reset();
		for (int i = 0; i < 8; i++)
			chain[i] = sm3_pkg::IV[255 - 32 * i -: 32];
		msg_bytes = '0;
	endfunction

	// One SM3 compression of blk into chain
	function automatic void compress();
		logic [31:0] w[68];
		logic [31:0] r[8];
		logic [31:0] tj, ss1, ss2, tt1, tt2, ff, gg;
		for (int j = 0; j < 16; j++)
			w[j] = blk[j];
		for (int j = 16; j < 68; j++)
			w[j] = perm1(w[j - 16] ^ w[j - 9] ^ rot(w[j - 3], 15)) ^ rot(w[j - 13], 7)
				^ w[j - 6];
		for (int i = 0; i < 8; i++)
			r[i] = chain[i];
		for (int j = 0; j < 64; j++) begin
			tj = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
			ss1 = rot(rot(r[0], 12) + r[4] + rot(tj, j), 7);
			ss2 = ss1 ^ rot(r[0], 12);
			if (j < 16) begin
				ff = r[0] ^ r[1] ^ r[2];
				gg = r[4] ^ r[5] ^ r[6];
			end else begin
				ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
				gg = (r[4] & r[5]) | (~r[4] & r[6]);
			end
			tt1 = ff + r[3] + ss2 + (w[j] ^ w[j + 4]);
			tt2 = gg + r[7] + ss1 + w[j];
			r[3] = r[2];
			r[2] = rot(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rot(r[5], 19);
			r[5] = r[4];
			r[4] = perm0(tt2);
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= r[i];
	endfunction

	function automatic void put_byte(input int unsigned pos, input logic [7:0] b);
		blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
	endfunction

	function automatic void put_length();
		logic [63:0] bits;
		bits = {msg_bytes, 3'b000};
		blk[14] = bits[63:32];
		blk[15] = bits[31:0];
	endfunction

	// Absorb one accepted word; on end of message pad and queue the digest
	function automatic void absorb_word(input in_word_t wd);
		int unsigned rem;
		out_word_t o;
		if (wd.byte_valid) begin
			put_byte(msg_bytes % 64, wd.data_byte);
			msg_bytes = msg_bytes + 1;
			if (msg_bytes % 64 == 0)
				compress();
		end
		if (!wd.end_of_message)
			return;
		rem = msg_bytes % 64;
		put_byte(rem, sm3_pkg::PAD_BYTE);
		for (int k = rem + 1; k < 64; k++)
			put_byte(k, 8'h00);
		if (rem >= 56) begin
			compress();
			for (int i = 0; i < 16; i++)
				blk[i] = '0;
		end
		put_length();
		compress();
		for (int k = 0; k < 8; k++) begin
			o.digest_word = chain[k];
			o.word_index = 3'(k);
			o.last_word = (k == 7);
			digest_expected.push_back(o);
		end
		chain_reset();
	endfunction

	function automatic void add_word(input logic [7:0] b, input bit bv, input bit eom);
		in_word_t wd;
		wd.data_byte = b;
		wd.byte_valid = bv;
		wd.end_of_message = eom;
		pending_words.push_back(wd);
		if (eom)
			digests_queued++;
	endfunction

	// Message of n random bytes; end flag either rides on the last byte or stands alone
	function automatic void add_message(input int unsigned n, input bit noisy);
		bit joined;
		joined = (n > 0) && $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				add_word(8'($urandom), 1'b0, 1'b0);
			add_word(8'($urandom), 1'b1, joined && (i == n - 1));
		end
		if (!joined)
			add_word(8'($urandom), 1'b0, 1'b1);
	endfunction

	// Driver: sends pending words with random idle bursts
	int unsigned src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			src_gap = 0;
		end else begin
			logic v_next;
			v_next = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				absorb_word(in_ch.data);
				v_next = 1'b0;
			end
			if (!v_next) begin
				if (src_gap > 0)
					src_gap--;
				else if (!quiet && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 18);
				else if (pending_words.size() > 0) begin
					in_ch.data <= pending_words.pop_front();
					v_next = 1'b1;
				end
			end
			in_ch.valid <= v_next;
		end
	end

	// Monitor: random back-pressure and digest word check
	int unsigned snk_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_word_t exp_w;
				if (digest_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h idx %0d last %0b",
							out_ch.data.digest_word, out_ch.data.word_index,
							out_ch.data.last_word);
				end else begin
					exp_w = digest_expected.pop_front();
					if (out_ch.data !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								exp_w.digest_word, exp_w.word_index, exp_w.last_word,
								out_ch.data.digest_word, out_ch.data.word_index,
								out_ch.data.last_word);
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				out_ch.ready <= (snk_gap == 0);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				snk_gap = $urandom_range(1, 18);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int unsigned n_words, len;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		digests_queued = 0;
		quiet = 1'b0;
		for (int i = 0; i < 16; i++)
			blk[i] = '0;
		chain_reset();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, single extreme bytes, idle word, "abc"
		add_word(8'h00, 1'b0, 1'b1);
		add_word(8'hFF, 1'b1, 1'b1);
		add_word(8'h00, 1'b1, 1'b0);
		add_word(8'hA5, 1'b0, 1'b0);
		add_word(8'h00, 1'b0, 1'b1);
		add_word(8'h61, 1'b1, 1'b0);
		add_word(8'h62, 1'b1, 1'b0);
		add_word(8'h63, 1'b1, 1'b0);
		add_word(8'h00, 1'b0, 1'b1);

		// Random messages, lengths biased to the padding boundaries
		n_words = 0;
		while (n_words < 240) begin
			case ($urandom_range(0, 5))
				0: len = 55 + $urandom_range(0, 1);
				1: len = 63 + $urandom_range(0, 2);
				2: len = 119 + $urandom_range(0, 1);
				default: len = $urandom_range(0, 20);
			endcase
			n_words += len + 1;
			add_message(len, $urandom_range(0, 3) == 0);
		end

		// Last part of the run goes without idling
		wait (pending_words.size() < 50);
		quiet = 1'b1;

		wait (pending_words.size() == 0 && !in_ch.valid);
		wait (digest_expected.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && digest_expected.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
